// ===== src/skt_pkg.sv =====
// shared types, constants and the scan code to ascii table for the scancode key tracker
// no dependencies
package skt_pkg;

  localparam int CODE_W     = 8;
  localparam int KIDX_W     = 8;
  localparam int HIDX_W     = 6;
  localparam int CHAR_W     = 7;
  localparam int MAP_DEPTH  = 256;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 24;

  localparam logic [CODE_W-1:0] PREFIX_CODE = 8'hE0;

  localparam logic ACT_SCAN  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef struct packed {
    logic              map_fwd;
    logic              map_fwd_val;
    logic              map_ok;
    logic              hist_fwd;
    logic              hist_ok;
    logic              pushed;
    logic [CHAR_W-1:0] pchar;
    logic              ext;
  } s1_t;

  function automatic logic [CHAR_W-1:0] ascii_of(input logic [6:0] code);
    logic [CHAR_W-1:0] c;
    case (code)
      7'd2:    c = 7'd49;
      7'd3:    c = 7'd50;
      7'd4:    c = 7'd51;
      7'd5:    c = 7'd52;
      7'd6:    c = 7'd53;
      7'd7:    c = 7'd54;
      7'd8:    c = 7'd55;
      7'd9:    c = 7'd56;
      7'd10:   c = 7'd57;
      7'd11:   c = 7'd48;
      7'd12:   c = 7'd45;
      7'd16:   c = 7'd113;
      7'd17:   c = 7'd119;
      7'd18:   c = 7'd101;
      7'd19:   c = 7'd114;
      7'd20:   c = 7'd116;
      7'd21:   c = 7'd121;
      7'd22:   c = 7'd117;
      7'd23:   c = 7'd105;
      7'd24:   c = 7'd111;
      7'd25:   c = 7'd112;
      7'd30:   c = 7'd97;
      7'd31:   c = 7'd115;
      7'd32:   c = 7'd100;
      7'd33:   c = 7'd102;
      7'd34:   c = 7'd103;
      7'd35:   c = 7'd104;
      7'd36:   c = 7'd106;
      7'd37:   c = 7'd107;
      7'd38:   c = 7'd108;
      7'd44:   c = 7'd122;
      7'd45:   c = 7'd120;
      7'd46:   c = 7'd99;
      7'd47:   c = 7'd118;
      7'd48:   c = 7'd98;
      7'd49:   c = 7'd110;
      7'd50:   c = 7'd109;
      7'd51:   c = 7'd44;
      7'd52:   c = 7'd46;
      7'd53:   c = 7'd47;
      7'd57:   c = 7'd32;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

// ===== src/scancode_key_tracker.sv =====
// top level of the scancode key tracker: pressed-key map and typed-character history
// depends on skt_pkg and skt_ram
//
// Takes one transfer per cycle unless out_tready stalls the output, and returns one
// result per item via memory read, then the output register. The pressed map sits in a
// 256 x 1 ram with a flip-flop valid bit per key, cleared at reset; the history is a
// circular buffer of HISTORY_DEPTH entries in a second ram, with a head pointer and a
// fill count, so no clearing pass is needed after reset. A read of the entry written by
// the same item is forwarded around the ram.
module scancode_key_tracker #(
  parameter int HISTORY_DEPTH = 49
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // scan_code[7:0], key_index[15:8], history_index[21:16], zero [23:22]
  input  logic [skt_pkg::IN_DATA_W-1:0]  in_tdata,
  // action[0]
  input  logic                           in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // key_down[0], history_char[7:1], pushed[8], pushed_char[15:9], extended_pending[16],
  // zero [23:17]
  output logic [skt_pkg::OUT_DATA_W-1:0] out_tdata
);

  localparam int AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int CW = $clog2(HISTORY_DEPTH + 1);
  localparam int SW = ((AW > skt_pkg::HIDX_W) ? AW : skt_pkg::HIDX_W) + 1;
  localparam logic [SW-1:0] DEPTH_S = SW'(HISTORY_DEPTH);

  logic                       acc;
  logic [skt_pkg::CODE_W-1:0] scan;
  logic [skt_pkg::KIDX_W-1:0] kidx;
  logic [skt_pkg::HIDX_W-1:0] hidx;
  logic                       upd;
  logic                       is_pre;
  logic                       press;
  logic                       rel;
  logic [7:0]                 key;
  logic [skt_pkg::CHAR_W-1:0] pchar;

  logic                       ext_r, ext_nxt;
  logic [skt_pkg::MAP_DEPTH-1:0] map_vld_r;
  logic                       map_we;
  logic                       map_rdata;

  logic [AW-1:0]              head_r, head_nxt;
  logic [CW-1:0]              cnt_r, cnt_nxt;
  logic [SW-1:0]              hsum;
  logic [SW-1:0]              hslot_s;
  logic [AW-1:0]              hslot;
  logic [skt_pkg::CHAR_W-1:0] hist_rdata;

  skt_pkg::s1_t               s1_r, s1_nxt;
  logic                       s1_v_r;
  logic                       s1_adv;
  logic                       out_v_r;
  logic [skt_pkg::OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic                       key_down;
  logic [skt_pkg::CHAR_W-1:0] hist_char;

  assign scan   = in_tdata[7:0];
  assign kidx   = in_tdata[15:8];
  assign hidx   = in_tdata[21:16];

  assign s1_adv    = s1_v_r && (!out_v_r || out_tready);
  assign in_tready = !s1_v_r || s1_adv;
  assign acc       = in_tvalid && in_tready;

  assign upd    = acc && (in_tuser == skt_pkg::ACT_SCAN);
  assign is_pre = (scan == skt_pkg::PREFIX_CODE);
  assign press  = upd && !is_pre && !scan[7];
  assign rel    = upd && !is_pre && scan[7];
  assign key    = {ext_r, scan[6:0]};
  assign pchar  = ext_r ? '0 : skt_pkg::ascii_of(scan[6:0]);
  assign map_we = press || rel;

  always_comb begin
    ext_nxt = ext_r;
    if (upd) begin
      ext_nxt = is_pre;
    end
  end

  // history pointer and fill count after this item
  always_comb begin
    head_nxt = head_r;
    cnt_nxt  = cnt_r;
    if (press) begin
      head_nxt = (head_r == '0) ? AW'(HISTORY_DEPTH - 1) : head_r - 1'b1;
      cnt_nxt  = (cnt_r == CW'(HISTORY_DEPTH)) ? cnt_r : cnt_r + 1'b1;
    end
  end

  assign hsum    = SW'(head_nxt) + SW'(hidx);
  assign hslot_s = (hsum >= DEPTH_S) ? hsum - DEPTH_S : hsum;
  assign hslot   = hslot_s[AW-1:0];

  skt_ram #(
    .WIDTH (1),
    .DEPTH (skt_pkg::MAP_DEPTH)
  ) u_map_ram (
    .clk   (clk),
    .we    (map_we),
    .waddr (key),
    .wdata (press),
    .re    (acc),
    .raddr (kidx),
    .rdata (map_rdata)
  );

  skt_ram #(
    .WIDTH (skt_pkg::CHAR_W),
    .DEPTH (HISTORY_DEPTH)
  ) u_hist_ram (
    .clk   (clk),
    .we    (press),
    .waddr (head_nxt),
    .wdata (pchar),
    .re    (acc),
    .raddr (hslot),
    .rdata (hist_rdata)
  );

  always_comb begin
    s1_nxt.map_fwd     = map_we && (key == kidx);
    s1_nxt.map_fwd_val = press;
    s1_nxt.map_ok      = map_vld_r[kidx];
    s1_nxt.hist_fwd    = press && (hidx == '0);
    s1_nxt.hist_ok     = SW'(hidx) < SW'(cnt_nxt);
    s1_nxt.pushed      = press;
    s1_nxt.pchar       = press ? pchar : '0;
    s1_nxt.ext         = ext_nxt;
  end

  assign key_down  = s1_r.map_fwd ? s1_r.map_fwd_val : (s1_r.map_ok & map_rdata);
  assign hist_char = s1_r.hist_fwd ? s1_r.pchar : (s1_r.hist_ok ? hist_rdata : '0);

  always_comb begin
    out_data_nxt        = '0;
    out_data_nxt[0]     = key_down;
    out_data_nxt[7:1]   = hist_char;
    out_data_nxt[8]     = s1_r.pushed;
    out_data_nxt[15:9]  = s1_r.pchar;
    out_data_nxt[16]    = s1_r.ext;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ext_r     <= 1'b0;
      map_vld_r <= '0;
      head_r    <= '0;
      cnt_r     <= '0;
      s1_v_r    <= 1'b0;
      out_v_r   <= 1'b0;
    end else begin
      ext_r  <= ext_nxt;
      head_r <= head_nxt;
      cnt_r  <= cnt_nxt;
      if (map_we) begin
        map_vld_r[key] <= 1'b1;
      end
      if (acc) begin
        s1_v_r <= 1'b1;
      end else if (s1_adv) begin
        s1_v_r <= 1'b0;
      end
      if (s1_adv) begin
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_r <= s1_nxt;
    end
    if (s1_adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(HISTORY_DEPTH))
    else $error("history fill count past depth");

  a_head_range: assert property (@(posedge clk) disable iff (!rst_n)
    SW'(head_r) < DEPTH_S)
    else $error("history head out of range");

  a_query_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_tuser == skt_pkg::ACT_QUERY) |=> ($stable(ext_r) && $stable(head_r)))
    else $error("query transfer changed state");

  a_push_char: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tdata[8]) |-> (out_tdata[15:9] == '0))
    else $error("pushed char without push");

endmodule

// ===== src/skt_ram.sv =====
// generic single-clock ram, one write port and one read port with registered read data
// no dependencies
module skt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
